@@ rtl/pfsp_pkg.sv @@
`default_nettype none

package pfsp_pkg;

  // Result kinds.
  localparam logic KIND_POINT  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Input modes.
  localparam logic MODE_DATA = 1'b0;
  localparam logic MODE_EOS  = 1'b1;

  // Status codes carried by a status report.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_MAGIC   = 3'd1;
  localparam logic [2:0] ST_VERSION = 3'd2;
  localparam logic [2:0] ST_POLYS   = 3'd3;
  localparam logic [2:0] ST_RINGS   = 3'd4;
  localparam logic [2:0] ST_POINTS  = 3'd5;
  localparam logic [2:0] ST_TRUNC   = 3'd6;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MAX_POLYGONS = 2'd0;
  localparam logic [1:0] CFG_MAX_RINGS    = 2'd1;
  localparam logic [1:0] CFG_MAX_POINTS   = 2'd2;

  // Reset values of the limit registers.
  localparam logic [31:0] MAX_POLYGONS_RESET = 32'd500000;
  localparam logic [31:0] MAX_RINGS_RESET    = 32'd100000;
  localparam logic [31:0] MAX_POINTS_RESET   = 32'd10000000;

  // File format constants.
  localparam logic [31:0] FILE_VERSION   = 32'd2;
  localparam logic [31:0] MIN_POINTS     = 32'd3;

  typedef struct packed {
    logic [31:0] max_polygons;
    logic [31:0] max_rings;
    logic [31:0] max_points;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  status_code;
    logic [31:0] x_bits;
    logic [31:0] y_bits;
    logic [31:0] polygon_index;
    logic [31:0] ring_index;
    logic [31:0] point_index;
    logic        last_in_ring;
    logic        last_in_polygon;
    logic        last_in_file;
  } out_item_t;

  // Expected magic byte at each position of the file header.
  function automatic logic [7:0] magic_byte(input logic [1:0] pos);
    logic [7:0] b;
    case (pos)
      2'd0:    b = 8'h43;
      2'd1:    b = 8'h57;
      2'd2:    b = 8'h76;
      default: b = 8'h32;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

@@ rtl/pfsp_in_if.sv @@
`default_nettype none

// Input stream: one file byte or an end-of-stream mark per request.
interface pfsp_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] byte_value;

  modport source (output valid, output mode, output byte_value, input ready);
  modport sink   (input valid, input mode, input byte_value, output ready);
endinterface

`default_nettype wire

@@ rtl/pfsp_out_if.sv @@
`default_nettype none

// Result stream: a point record or a status report per request.
interface pfsp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [2:0]  status_code;
  logic [31:0] x_bits;
  logic [31:0] y_bits;
  logic [31:0] polygon_index;
  logic [31:0] ring_index;
  logic [31:0] point_index;
  logic        last_in_ring;
  logic        last_in_polygon;
  logic        last_in_file;

  modport source (
    output valid, output kind, output status_code, output x_bits, output y_bits,
    output polygon_index, output ring_index, output point_index,
    output last_in_ring, output last_in_polygon, output last_in_file,
    input ready
  );
  modport sink (
    input valid, input kind, input status_code, input x_bits, input y_bits,
    input polygon_index, input ring_index, input point_index,
    input last_in_ring, input last_in_polygon, input last_in_file,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/pfsp_cfg_if.sv @@
`default_nettype none

// Configuration write channel.
interface pfsp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/polygon_file_stream_parser_core.sv @@
`default_nettype none

// Path: an accepted byte is held in the input register, and its result, if any,
// is loaded into the result register once that register is free or being emptied.
// Throughput: one byte or end-of-stream item per cycle, limited only by the
// result register being taken; the parse state is computed combinationally.
// Reset: rst_ni clears the parser to the magic phase and the limit registers
// to their default values; no clearing pass is needed.

module polygon_file_stream_parser_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pfsp_in_if.sink   in_i,
  pfsp_cfg_if.sink  cfg_i,
  pfsp_out_if.source out_o
);
  import pfsp_pkg::*;

  cfg_t       cfg;
  logic       in_valid_q, in_valid_d;
  logic       in_mode_q;
  logic [7:0] in_byte_q;
  logic       advance;
  logic       res_valid;
  out_item_t  res;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_q;

  // The held item moves on once the result register is free or being emptied.
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  pfsp_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  pfsp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .mode_i      (in_mode_q),
    .byte_i      (in_byte_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Input register.
  always_comb begin
    in_valid_d = in_valid_q;
    if (in_i.ready) begin
      in_valid_d = in_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_mode_q <= in_i.mode;
      in_byte_q <= in_i.byte_value;
    end
  end

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = res_valid;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.kind            = out_q.kind;
  assign out_o.status_code     = out_q.status_code;
  assign out_o.x_bits          = out_q.x_bits;
  assign out_o.y_bits          = out_q.y_bits;
  assign out_o.polygon_index   = out_q.polygon_index;
  assign out_o.ring_index      = out_q.ring_index;
  assign out_o.point_index     = out_q.point_index;
  assign out_o.last_in_ring    = out_q.last_in_ring;
  assign out_o.last_in_polygon = out_q.last_in_polygon;
  assign out_o.last_in_file    = out_q.last_in_file;

endmodule

`default_nettype wire

@@ rtl/pfsp_cfg_regs.sv @@
`default_nettype none

module pfsp_cfg_regs (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  pfsp_cfg_if.sink         cfg_i,
  output pfsp_pkg::cfg_t   cfg_o
);
  import pfsp_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Writes are always taken; an index past the last register is dropped.
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_MAX_POLYGONS: cfg_d.max_polygons = cfg_i.data;
        CFG_MAX_RINGS:    cfg_d.max_rings    = cfg_i.data;
        CFG_MAX_POINTS:   cfg_d.max_points   = cfg_i.data;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_polygons <= MAX_POLYGONS_RESET;
      cfg_q.max_rings    <= MAX_RINGS_RESET;
      cfg_q.max_points   <= MAX_POINTS_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/pfsp_parser.sv @@
`default_nettype none

module pfsp_parser (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_i,
  input  wire logic          mode_i,
  input  wire logic [7:0]    byte_i,
  input  wire pfsp_pkg::cfg_t cfg_i,
  output logic               res_valid_o,
  output pfsp_pkg::out_item_t res_o
);
  import pfsp_pkg::*;

  // Parse phases.
  localparam logic [2:0] PH_MAGIC   = 3'd0;
  localparam logic [2:0] PH_VERSION = 3'd1;
  localparam logic [2:0] PH_POLYS   = 3'd2;
  localparam logic [2:0] PH_RINGS   = 3'd3;
  localparam logic [2:0] PH_POINTS  = 3'd4;
  localparam logic [2:0] PH_X       = 3'd5;
  localparam logic [2:0] PH_Y       = 3'd6;

  // Halt states.
  localparam logic [1:0] HALT_RUN  = 2'd0;
  localparam logic [1:0] HALT_DONE = 2'd1;
  localparam logic [1:0] HALT_FAIL = 2'd2;

  logic [2:0]  phase_q, phase_d;
  logic [1:0]  biw_q, biw_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] held_x_q, held_x_d;
  logic [31:0] poly_total_q, poly_total_d;
  logic [31:0] ring_total_q, ring_total_d;
  logic [31:0] point_total_q, point_total_d;
  logic [31:0] poly_cnt_q, poly_cnt_d;
  logic [31:0] ring_cnt_q, ring_cnt_d;
  logic [31:0] point_cnt_q, point_cnt_d;
  logic [1:0]  halt_q, halt_d;

  logic [31:0] word;
  logic        last_ring, last_poly, last_file;
  logic [31:0] poly_cnt_inc, ring_cnt_inc, point_cnt_inc;

  // Little-endian word assembly: the new byte lands at its lane.
  always_comb begin
    word = acc_q;
    word[{biw_q, 3'b000} +: 8] = byte_i;
  end

  // Closing flags of the point being completed.
  assign poly_cnt_inc  = poly_cnt_q + 32'd1;
  assign ring_cnt_inc  = ring_cnt_q + 32'd1;
  assign point_cnt_inc = point_cnt_q + 32'd1;
  assign last_ring = (point_cnt_inc == point_total_q);
  assign last_poly = last_ring && (ring_cnt_inc == ring_total_q);
  assign last_file = last_poly && (poly_cnt_inc == poly_total_q);

  // Next state and result for the item presented this cycle.
  always_comb begin
    phase_d       = phase_q;
    biw_d         = biw_q;
    acc_d         = acc_q;
    held_x_d      = held_x_q;
    poly_total_d  = poly_total_q;
    ring_total_d  = ring_total_q;
    point_total_d = point_total_q;
    poly_cnt_d    = poly_cnt_q;
    ring_cnt_d    = ring_cnt_q;
    point_cnt_d   = point_cnt_q;
    halt_d        = halt_q;
    res_valid_o   = 1'b0;
    res_o         = '0;

    if (mode_i == MODE_EOS) begin
      // End of stream rearms; a failure was reported already.
      phase_d       = PH_MAGIC;
      biw_d         = 2'd0;
      acc_d         = '0;
      held_x_d      = '0;
      poly_total_d  = '0;
      ring_total_d  = '0;
      point_total_d = '0;
      poly_cnt_d    = '0;
      ring_cnt_d    = '0;
      point_cnt_d   = '0;
      halt_d        = HALT_RUN;
      if (halt_q != HALT_FAIL) begin
        res_valid_o       = 1'b1;
        res_o.kind        = KIND_STATUS;
        res_o.status_code = (halt_q == HALT_DONE) ? ST_OK : ST_TRUNC;
      end
    end else if (halt_q == HALT_RUN) begin
      if (phase_q == PH_MAGIC) begin
        if (byte_i != magic_byte(biw_q)) begin
          halt_d            = HALT_FAIL;
          res_valid_o       = 1'b1;
          res_o.kind        = KIND_STATUS;
          res_o.status_code = ST_MAGIC;
        end else if (biw_q == 2'd3) begin
          biw_d   = 2'd0;
          phase_d = PH_VERSION;
        end else begin
          biw_d = biw_q + 2'd1;
        end
      end else if (biw_q != 2'd3) begin
        acc_d = word;
        biw_d = biw_q + 2'd1;
      end else begin
        biw_d = 2'd0;
        acc_d = '0;
        case (phase_q)
          PH_VERSION: begin
            if (word != FILE_VERSION) begin
              halt_d            = HALT_FAIL;
              res_valid_o       = 1'b1;
              res_o.kind        = KIND_STATUS;
              res_o.status_code = ST_VERSION;
            end else begin
              phase_d = PH_POLYS;
            end
          end
          PH_POLYS: begin
            if (word == '0 || word > cfg_i.max_polygons) begin
              halt_d            = HALT_FAIL;
              res_valid_o       = 1'b1;
              res_o.kind        = KIND_STATUS;
              res_o.status_code = ST_POLYS;
            end else begin
              poly_total_d = word;
              phase_d      = PH_RINGS;
            end
          end
          PH_RINGS: begin
            if (word == '0 || word > cfg_i.max_rings) begin
              halt_d            = HALT_FAIL;
              res_valid_o       = 1'b1;
              res_o.kind        = KIND_STATUS;
              res_o.status_code = ST_RINGS;
            end else begin
              ring_total_d = word;
              phase_d      = PH_POINTS;
            end
          end
          PH_POINTS: begin
            if (word < MIN_POINTS || word > cfg_i.max_points) begin
              halt_d            = HALT_FAIL;
              res_valid_o       = 1'b1;
              res_o.kind        = KIND_STATUS;
              res_o.status_code = ST_POINTS;
            end else begin
              point_total_d = word;
              phase_d       = PH_X;
            end
          end
          PH_X: begin
            held_x_d = word;
            phase_d  = PH_Y;
          end
          PH_Y: begin
            res_valid_o           = 1'b1;
            res_o.kind            = KIND_POINT;
            res_o.status_code     = ST_OK;
            res_o.x_bits          = held_x_q;
            res_o.y_bits          = word;
            res_o.polygon_index   = poly_cnt_q;
            res_o.ring_index      = ring_cnt_q;
            res_o.point_index     = point_cnt_q;
            res_o.last_in_ring    = last_ring;
            res_o.last_in_polygon = last_poly;
            res_o.last_in_file    = last_file;
            if (!last_ring) begin
              point_cnt_d = point_cnt_inc;
              phase_d     = PH_X;
            end else if (!last_poly) begin
              point_cnt_d = '0;
              ring_cnt_d  = ring_cnt_inc;
              phase_d     = PH_POINTS;
            end else if (!last_file) begin
              point_cnt_d = '0;
              ring_cnt_d  = '0;
              poly_cnt_d  = poly_cnt_inc;
              phase_d     = PH_RINGS;
            end else begin
              point_cnt_d = '0;
              ring_cnt_d  = '0;
              poly_cnt_d  = '0;
              halt_d      = HALT_DONE;
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
    end
  end

  // Parser state advances only when the item is taken into the result stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_MAGIC;
      biw_q         <= 2'd0;
      acc_q         <= '0;
      held_x_q      <= '0;
      poly_total_q  <= '0;
      ring_total_q  <= '0;
      point_total_q <= '0;
      poly_cnt_q    <= '0;
      ring_cnt_q    <= '0;
      point_cnt_q   <= '0;
      halt_q        <= HALT_RUN;
    end else if (step_i) begin
      phase_q       <= phase_d;
      biw_q         <= biw_d;
      acc_q         <= acc_d;
      held_x_q      <= held_x_d;
      poly_total_q  <= poly_total_d;
      ring_total_q  <= ring_total_d;
      point_total_q <= point_total_d;
      poly_cnt_q    <= poly_cnt_d;
      ring_cnt_q    <= ring_cnt_d;
      point_cnt_q   <= point_cnt_d;
      halt_q        <= halt_d;
    end
  end

`ifndef ASSERT_OFF
  // An end-of-stream item always leaves the parser rearmed.
  a_eos_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && mode_i == MODE_EOS |=> phase_q == PH_MAGIC && halt_q == HALT_RUN)
    else $error("parser not rearmed after end of stream");

  // A halted parser produces nothing for data bytes.
  a_halted_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q != HALT_RUN && mode_i == MODE_DATA |-> !res_valid_o)
    else $error("result produced while halted");

  // An error report on a data byte puts the parser into the failed state.
  a_error_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_valid_o && mode_i == MODE_DATA && res_o.kind == KIND_STATUS
    |=> halt_q == HALT_FAIL)
    else $error("error report without halting");

  // The closing flags nest: a file end closes its polygon, which closes its ring.
  a_flags_nest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == KIND_POINT
    |-> (!res_o.last_in_file || res_o.last_in_polygon)
        && (!res_o.last_in_polygon || res_o.last_in_ring))
    else $error("closing flags do not nest");
`endif

endmodule

`default_nettype wire
